// ----- rtl/rpl_pkg.sv -----
// ----------------------------------------------------------------------------
// rpl_pkg: shared definitions for the RSSI peak lap timer
// Operation codes, register indexes, widths and the drop constants.
// ----------------------------------------------------------------------------
package rpl_pkg;

    // Operation codes carried in s_tuser
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_SAMPLE        = 3'd0;
    localparam logic [OP_W-1:0] OP_START         = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP          = 3'd2;
    localparam logic [OP_W-1:0] OP_NOISE_CAL_ON  = 3'd3;
    localparam logic [OP_W-1:0] OP_NOISE_CAL_OFF = 3'd4;
    localparam logic [OP_W-1:0] OP_CROSS_CAL_ON  = 3'd5;
    localparam logic [OP_W-1:0] OP_CROSS_CAL_OFF = 3'd6;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_ENTER_THRESHOLD  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_LAP_MS       = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GATE_DIAMETER_MM = 2'd2;

    // Field widths
    localparam int RSSI_W    = 8;
    localparam int TIME_W    = 32;
    localparam int GATE_W    = 16;
    localparam int COUNT_W   = 16;
    localparam int SLOT_W    = 3;

    // Stream widths: input data {time_ms, rssi_sample}, output as listed at the ports
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 88;

    // Lap history depth; the lap index wraps at this count
    localparam int LAP_SLOTS = 8;
    localparam int LAP_IDX_W = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1;

    // Peak drop rule
    localparam logic [GATE_W-1:0] GATE_WIDE_MM = 16'd1000;
    localparam logic [RSSI_W-1:0] DROP_WIDE    = 8'd10;
    localparam logic [RSSI_W-1:0] DROP_NARROW  = 8'd6;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

endpackage

// ----- rtl/rssi_peak_lap_timer.sv -----
// ----------------------------------------------------------------------------
// rssi_peak_lap_timer: lap timing from filtered RSSI samples
// Peak tracking with a drop detector, plus noise and crossing calibration.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock on the slave side while the
// result register is not stalled, and returns exactly one result transaction
// per input on the master side, in order. An input transaction is registered
// in the input register, then evaluated against the timing state as it moves
// on, and the result is registered in the result register. The sustained
// rate is one transaction per cycle while m_tready does not stall the
// result register, set by the update of the lap state (the hold-off
// subtract and compare, the peak compare and the drop compare). Backpressure
// on m_tready stalls the result register; the input register then takes one
// more transaction and holds it, and s_tready stays low until the result
// register can move again. Configuration writes should only be issued while
// no transaction is in flight.
module rssi_peak_lap_timer (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [rpl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [rpl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, lowest bit first: rssi_sample[7:0], time_ms[39:8]
    input  logic [rpl_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: op[2:0]
    input  logic [rpl_pkg::OP_W-1:0]          s_tuser,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, lowest bit first: lap_done[0], lap_time[32:1], lap_slot[35:33],
    // is_running[36], noise_max[44:37], noise_count[60:45],
    // crossing_max[68:61], crossing_count[84:69], zero fill[87:85]
    output logic [rpl_pkg::M_TDATA_W-1:0]     m_tdata
);
    import rpl_pkg::*;

    // Configuration registers
    logic [RSSI_W-1:0]  enter_threshold_reg;
    logic [TIME_W-1:0]  min_lap_ms_reg;
    logic [GATE_W-1:0]  gate_diameter_mm_reg;

    // Input register stage
    logic               in_valid_reg;
    logic [OP_W-1:0]    in_op_reg;
    logic [RSSI_W-1:0]  in_rssi_reg;
    logic [TIME_W-1:0]  in_time_reg;

    // Timing and calibration state
    logic                 running_reg,         running_next;
    logic [TIME_W-1:0]    lap_start_reg,       lap_start_next;
    logic [RSSI_W-1:0]    peak_value_reg,      peak_value_next;
    logic [TIME_W-1:0]    peak_time_reg,       peak_time_next;
    logic [TIME_W-1:0]    last_lap_reg,        last_lap_next;
    logic [LAP_IDX_W-1:0] lap_index_reg,       lap_index_next;
    logic                 noise_on_reg,        noise_on_next;
    logic                 cross_on_reg,        cross_on_next;
    logic [RSSI_W-1:0]    noise_peak_reg,      noise_peak_next;
    logic [COUNT_W-1:0]   noise_count_reg,     noise_count_next;
    logic [RSSI_W-1:0]    cross_peak_reg,      cross_peak_next;
    logic [COUNT_W-1:0]   cross_count_reg,     cross_count_next;
    logic                 lap_done_next;

    // Result register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;

    logic                 advance;
    logic                 fire;
    logic [TIME_W-1:0]    since_start;
    logic                 new_peak;
    logic [RSSI_W-1:0]    drop;
    logic [LAP_IDX_W+2:0] slot_ext;

    // The result register moves whenever it is empty or being taken, and the
    // input register refills whenever its contents move on.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enter_threshold_reg  <= '0;
            min_lap_ms_reg       <= '0;
            gate_diameter_mm_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ENTER_THRESHOLD:  enter_threshold_reg  <= cfg_wdata[RSSI_W-1:0];
                REG_MIN_LAP_MS:       min_lap_ms_reg       <= cfg_wdata[TIME_W-1:0];
                REG_GATE_DIAMETER_MM: gate_diameter_mm_reg <= cfg_wdata[GATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_rssi_reg <= s_tdata[RSSI_W-1:0];
            in_time_reg <= s_tdata[RSSI_W+TIME_W-1:RSSI_W];
        end
    end

    // Time since the lap started, modulo 2^32, for the hold-off test.
    assign since_start = in_time_reg - lap_start_reg;
    assign drop = (gate_diameter_mm_reg == GATE_WIDE_MM) ? DROP_WIDE : DROP_NARROW;

    always_comb begin
        running_next     = running_reg;
        lap_start_next   = lap_start_reg;
        peak_value_next  = peak_value_reg;
        peak_time_next   = peak_time_reg;
        last_lap_next    = last_lap_reg;
        lap_index_next   = lap_index_reg;
        noise_on_next    = noise_on_reg;
        cross_on_next    = cross_on_reg;
        noise_peak_next  = noise_peak_reg;
        noise_count_next = noise_count_reg;
        cross_peak_next  = cross_peak_reg;
        cross_count_next = cross_count_reg;
        lap_done_next    = 1'b0;
        new_peak         = 1'b0;

        case (in_op_reg)
            OP_SAMPLE: begin
                // Calibration sees every sample, running or not.
                if (noise_on_reg) begin
                    if (noise_count_reg != COUNT_MAX) begin
                        noise_count_next = noise_count_reg + 1'b1;
                    end
                    if (in_rssi_reg > noise_peak_reg) begin
                        noise_peak_next = in_rssi_reg;
                    end
                end
                if (cross_on_reg) begin
                    if (cross_count_reg != COUNT_MAX) begin
                        cross_count_next = cross_count_reg + 1'b1;
                    end
                    if (in_rssi_reg > cross_peak_reg) begin
                        cross_peak_next = in_rssi_reg;
                    end
                end
                if (running_reg) begin
                    new_peak = (since_start > min_lap_ms_reg)
                            && (in_rssi_reg >= enter_threshold_reg)
                            && (in_rssi_reg > peak_value_reg);
                    if (new_peak) begin
                        peak_value_next = in_rssi_reg;
                        peak_time_next  = in_time_reg;
                    end
                    // A new peak equals the sample, so only a held peak can
                    // end the lap; a lap may still end inside the hold-off.
                    if (!new_peak && (in_rssi_reg < peak_value_reg)
                            && ((peak_value_reg - in_rssi_reg) >= drop)) begin
                        lap_done_next   = 1'b1;
                        last_lap_next   = peak_time_reg - lap_start_reg;
                        lap_start_next  = peak_time_reg;
                        peak_value_next = '0;
                        peak_time_next  = '0;
                        if (lap_index_reg == LAP_IDX_W'(LAP_SLOTS - 1)) begin
                            lap_index_next = '0;
                        end else begin
                            lap_index_next = lap_index_reg + 1'b1;
                        end
                    end
                end
            end
            OP_START, OP_STOP: begin
                running_next    = (in_op_reg == OP_START);
                lap_start_next  = '0;
                peak_value_next = '0;
                peak_time_next  = '0;
                last_lap_next   = '0;
                lap_index_next  = '0;
            end
            OP_NOISE_CAL_ON: begin
                noise_on_next    = 1'b1;
                noise_peak_next  = '0;
                noise_count_next = '0;
            end
            OP_NOISE_CAL_OFF: begin
                noise_on_next = 1'b0;
            end
            OP_CROSS_CAL_ON: begin
                cross_on_next    = 1'b1;
                cross_peak_next  = '0;
                cross_count_next = '0;
            end
            OP_CROSS_CAL_OFF: begin
                cross_on_next = 1'b0;
            end
            default: ;
        endcase
    end

    // The reported slot is the low bits of the lap index.
    assign slot_ext = {3'b000, lap_index_next};

    assign out_data_next = {3'b000,
                            cross_count_next,
                            cross_peak_next,
                            noise_count_next,
                            noise_peak_next,
                            running_next,
                            slot_ext[SLOT_W-1:0],
                            last_lap_next,
                            lap_done_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg     <= 1'b0;
            lap_start_reg   <= '0;
            peak_value_reg  <= '0;
            peak_time_reg   <= '0;
            last_lap_reg    <= '0;
            lap_index_reg   <= '0;
            noise_on_reg    <= 1'b0;
            cross_on_reg    <= 1'b0;
            noise_peak_reg  <= '0;
            noise_count_reg <= '0;
            cross_peak_reg  <= '0;
            cross_count_reg <= '0;
        end else if (fire) begin
            running_reg     <= running_next;
            lap_start_reg   <= lap_start_next;
            peak_value_reg  <= peak_value_next;
            peak_time_reg   <= peak_time_next;
            last_lap_reg    <= last_lap_next;
            lap_index_reg   <= lap_index_next;
            noise_on_reg    <= noise_on_next;
            cross_on_reg    <= cross_on_next;
            noise_peak_reg  <= noise_peak_next;
            noise_count_reg <= noise_count_next;
            cross_peak_reg  <= cross_peak_next;
            cross_count_reg <= cross_count_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ----- rtl/rpl_checker.sv -----
// ----------------------------------------------------------------------------
// rpl_checker: port-level assertions for the RSSI peak lap timer
// Watches the stream ports and is attached to the top level by a bind.
// ----------------------------------------------------------------------------
module rpl_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [rpl_pkg::M_TDATA_W-1:0] m_tdata
);
    import rpl_pkg::*;

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A result appears only after a matching accepted input transaction.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching input transaction");

    // A lap can only finish while timing is running.
    a_done_running: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[36])
        else $error("lap finished while stopped");

    // While stopped, lap time and slot stay cleared.
    a_stopped_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[36] |-> (m_tdata[35:1] == '0))
        else $error("lap state not cleared while stopped");

endmodule

bind rssi_peak_lap_timer rpl_checker u_rpl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
